// ===== design/pid_speed_throttle_brake_defines.svh =====
// Assertion macros used by the checker file of the speed PID block.
`ifndef PID_SPEED_THROTTLE_BRAKE_DEFINES_SVH
`define PID_SPEED_THROTTLE_BRAKE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pstb: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PSTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pstb: next-cycle check failed");

`endif

// ===== design/pstb_pkg.sv =====
// Package: widths, constants and register codes of the speed PID block.
package pstb_pkg;

    localparam int SPEED_W = 32;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 24;
    localparam int CMD_W   = 17;
    localparam int INT_W   = 48;
    localparam int MAG_W   = 49;
    localparam int SLICE_W = 25;
    localparam int PP_W    = SLICE_W + GAIN_W;
    localparam int PROD_W  = MAG_W + GAIN_W;
    localparam int SUM_W   = 60;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd501763;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd430;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd13;

    localparam logic [PROD_W-1:0] TERM_LIM  = PROD_W'(1) << 56;
    localparam logic [SUM_W-1:0]  ONE_Q32   = SUM_W'(1) << 32;
    localparam logic [CMD_W-1:0]  CMD_FULL  = CMD_W'(1) << 16;
    localparam logic [35:0]       Q16_ONE   = 36'd65536;
    localparam logic [35:0]       ERR_SCALE = 36'd10;
    localparam logic [39:0]       ACC_SCALE = 40'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 2'd0,
        REG_GAIN_P = 2'd1,
        REG_GAIN_I = 2'd2,
        REG_GAIN_D = 2'd3
    } t_cfg_reg;

endpackage

// ===== design/pstb_channels.sv =====
// Handshake channel interfaces: configuration, speed sample and command result.
interface pstb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pstb_pkg::CFG_IDX_W-1:0]  index;
    logic [pstb_pkg::SPEED_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pstb_in_if;
    logic                          valid;
    logic                          ready;
    logic [pstb_pkg::SPEED_W-1:0]  measured_speed;
    logic [pstb_pkg::DT_W-1:0]     time_step;

    modport source (output valid, output measured_speed, output time_step, input ready);
    modport sink   (input valid, input measured_speed, input time_step, output ready);
endinterface

interface pstb_out_if;
    logic                        valid;
    logic                        ready;
    logic [pstb_pkg::CMD_W-1:0]  throttle;
    logic [pstb_pkg::CMD_W-1:0]  brake;
    logic                        speed_reached;

    modport source (output valid, output throttle, output brake, output speed_reached,
                    input ready);
    modport sink   (input valid, input throttle, input brake, input speed_reached,
                    output ready);
endinterface

// ===== design/pid_speed_throttle_brake.sv =====
// Speed PID controller with conditional integration and throttle/brake split.
//
// One speed sample is taken at a time; in.ready is low from acceptance until
// the command result has been transferred, including while the result waits
// for out.ready. The P term always runs; the I term and the integral update
// run only when the integral is active, and the derivative path only when
// time_step is nonzero. The derivative rate comes from a 49-step restoring
// divider (one quotient bit per cycle), and each of the up to four products
// is built from a low and a high slice on the single 25x24 multiplier, then
// accumulated. Configuration writes are taken every cycle and must only be
// issued while no sample is in flight.
module pid_speed_throttle_brake (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pstb_cfg_if.sink    i_cfg,
    pstb_in_if.sink     i_in,
    pstb_out_if.source  o_out
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_ERR     = 10'b0000000010,
        ST_MUL_LO  = 10'b0000000100,
        ST_MUL_HI  = 10'b0000001000,
        ST_MUL_ACC = 10'b0000010000,
        ST_TERM    = 10'b0000100000,
        ST_DCHK    = 10'b0001000000,
        ST_DIV     = 10'b0010000000,
        ST_FIN     = 10'b0100000000,
        ST_OUT     = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        OP_P   = 2'd0,
        OP_I   = 2'd1,
        OP_INT = 2'd2,
        OP_D   = 2'd3
    } t_op;

    t_state r_state, n_state;
    t_op    r_op;

    logic [pstb_pkg::SPEED_W-1:0] r_target;
    logic [pstb_pkg::GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [pstb_pkg::INT_W-1:0]   r_integral;
    logic [pstb_pkg::SPEED_W-1:0] r_prev_err, r_prev_speed;
    logic                         r_reached;

    logic [pstb_pkg::SPEED_W-1:0] r_speed, r_err;
    logic [pstb_pkg::DT_W-1:0]    r_dt;
    logic [pstb_pkg::MAG_W-1:0]   r_mul_a;
    logic [pstb_pkg::GAIN_W-1:0]  r_mul_b;
    logic                         r_sign;
    logic [pstb_pkg::PP_W-1:0]    r_pp;
    logic [pstb_pkg::PROD_W-1:0]  r_prod;
    logic [pstb_pkg::SUM_W-1:0]   r_sum;
    logic [pstb_pkg::DT_W-1:0]    r_rem;
    logic [pstb_pkg::CNT_W-1:0]   r_cnt;
    logic [pstb_pkg::CMD_W-1:0]   r_throttle, r_brake;

    logic                         in_xfer, out_xfer, cfg_xfer;
    logic [pstb_pkg::SPEED_W:0]   err_full;
    logic [pstb_pkg::SPEED_W-1:0] n_err, n_err_mag, err_mag;
    logic                         int_en;
    logic [pstb_pkg::INT_W-1:0]   int_mag;
    logic [pstb_pkg::SLICE_W-1:0] mul_x;
    logic [pstb_pkg::PP_W-1:0]    pp;
    logic                         term_sat;
    logic [56:0]                  term_mag;
    logic [pstb_pkg::SUM_W-1:0]   term_u, term_s;
    logic [pstb_pkg::MAG_W-1:0]   inc_u, inc_v;
    logic [pstb_pkg::SPEED_W:0]   inc_q;
    logic [pstb_pkg::INT_W:0]     int_sum;
    logic [pstb_pkg::INT_W-1:0]   int_new;
    logic [pstb_pkg::SPEED_W:0]   diff, diff_mag;
    logic [pstb_pkg::DT_W:0]      rem2, rem_sub;
    logic                         q_bit;
    logic [pstb_pkg::SUM_W-1:0]   sum_abs;
    logic [pstb_pkg::CMD_W-1:0]   cmd;
    logic [pstb_pkg::SPEED_W:0]   dsp, dsp_mag;
    logic                         steady;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid         = (r_state == ST_OUT);
    assign o_out.throttle      = r_throttle;
    assign o_out.brake         = r_brake;
    assign o_out.speed_reached = r_reached;

    // error, saturated to 32 bits
    assign err_full  = {r_target[31], r_target} - {r_speed[31], r_speed};
    assign n_err     = (err_full[32] != err_full[31]) ?
                       (err_full[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : err_full[31:0];
    assign n_err_mag = n_err[31] ? (~n_err + 32'd1) : n_err;
    assign err_mag   = r_err[31] ? (~r_err + 32'd1) : r_err;
    assign int_en    = $signed({1'b0, err_mag, 2'b00}) < $signed({{3{r_target[31]}}, r_target});
    assign int_mag   = r_integral[47] ? (~r_integral + 48'd1) : r_integral;

    // shared multiplier: low slice, then high slice of the magnitude operand
    assign mul_x = (r_state == ST_MUL_LO) ? r_mul_a[24:0] : {1'b0, r_mul_a[48:25]};
    assign pp    = {24'd0, mul_x} * {25'd0, r_mul_b};

    assign term_sat = r_prod > pstb_pkg::TERM_LIM;
    assign term_mag = term_sat ? (57'd1 << 56) : r_prod[56:0];
    assign term_u   = {3'b000, term_mag};
    assign term_s   = r_sign ? (~term_u + 60'd1) : term_u;

    // integral step: floor((err*dt) / 2^16), then 48-bit saturation
    assign inc_u   = {1'b0, r_prod[47:0]};
    assign inc_v   = r_sign ? (~inc_u + 49'd1) : inc_u;
    assign inc_q   = inc_v[48:16];
    assign int_sum = {r_integral[47], r_integral} + {{16{inc_q[32]}}, inc_q};
    assign int_new = (int_sum[48] != int_sum[47]) ?
                     (int_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : int_sum[47:0];

    assign diff     = {r_err[31], r_err} - {r_prev_err[31], r_prev_err};
    assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

    assign rem2    = {r_rem, r_mul_a[48]};
    assign q_bit   = rem2 >= {1'b0, r_dt};
    assign rem_sub = rem2 - {1'b0, r_dt};

    assign sum_abs = r_sum[59] ? (~r_sum + 60'd1) : r_sum;
    assign cmd     = (sum_abs > pstb_pkg::ONE_Q32) ? pstb_pkg::CMD_FULL : sum_abs[32:16];

    assign dsp     = {r_speed[31], r_speed} - {r_prev_speed[31], r_prev_speed};
    assign dsp_mag = dsp[32] ? (~dsp + 33'd1) : dsp;
    assign steady  = (r_dt != '0)
                  && ((40'(dsp_mag) * pstb_pkg::ACC_SCALE) < 40'(r_dt))
                  && ((36'(err_mag) * pstb_pkg::ERR_SCALE) < pstb_pkg::Q16_ONE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (in_xfer) n_state = ST_ERR;
            ST_ERR:     n_state = ST_MUL_LO;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_MUL_ACC;
            ST_MUL_ACC: n_state = ST_TERM;
            ST_TERM: begin
                unique case (r_op)
                    OP_P:   n_state = int_en ? ST_MUL_LO : ST_DCHK;
                    OP_I:   n_state = ST_MUL_LO;
                    OP_INT: n_state = ST_DCHK;
                    OP_D:   n_state = ST_FIN;
                endcase
            end
            ST_DCHK:    n_state = (r_dt != '0) ? ST_DIV : ST_FIN;
            ST_DIV: begin
                if (r_cnt == pstb_pkg::CNT_W'(pstb_pkg::MAG_W - 1)) n_state = ST_MUL_LO;
            end
            ST_FIN:     n_state = ST_OUT;
            ST_OUT:     if (out_xfer) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_target     <= '0;
            r_gain_p     <= pstb_pkg::GAIN_P_RST;
            r_gain_i     <= pstb_pkg::GAIN_I_RST;
            r_gain_d     <= pstb_pkg::GAIN_D_RST;
            r_integral   <= '0;
            r_prev_err   <= '0;
            r_prev_speed <= '0;
            r_reached    <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_speed <= i_in.measured_speed;
                        r_dt    <= i_in.time_step;
                    end
                end
                ST_ERR: begin
                    r_err   <= n_err;
                    r_mul_a <= pstb_pkg::MAG_W'(n_err_mag);
                    r_mul_b <= r_gain_p;
                    r_sign  <= n_err[31];
                    r_op    <= OP_P;
                end
                ST_MUL_LO: r_pp <= pp;
                ST_MUL_HI: begin
                    r_prod <= pstb_pkg::PROD_W'(r_pp);
                    r_pp   <= pp;
                end
                ST_MUL_ACC: r_prod <= r_prod + pstb_pkg::PROD_W'({r_pp, 25'd0});
                ST_TERM: begin
                    unique case (r_op)
                        OP_P: begin
                            r_sum   <= term_s;
                            r_mul_a <= {1'b0, int_mag};
                            r_mul_b <= r_gain_i;
                            r_sign  <= r_integral[47];
                            r_op    <= OP_I;
                        end
                        OP_I: begin
                            r_sum   <= r_sum + term_s;
                            r_mul_a <= pstb_pkg::MAG_W'(err_mag);
                            r_mul_b <= pstb_pkg::GAIN_W'(r_dt);
                            r_sign  <= r_err[31];
                            r_op    <= OP_INT;
                        end
                        OP_INT: r_integral <= int_new;
                        OP_D:   r_sum <= r_sum + term_s;
                    endcase
                end
                ST_DCHK: begin
                    r_mul_a <= {diff_mag, 16'd0};
                    r_sign  <= diff[32];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_rem   <= q_bit ? rem_sub[15:0] : rem2[15:0];
                    r_mul_a <= {r_mul_a[47:0], q_bit};
                    r_cnt   <= r_cnt + 1'b1;
                    r_mul_b <= r_gain_d;
                    r_op    <= OP_D;
                end
                ST_FIN: begin
                    r_throttle   <= r_sum[59] ? '0 : cmd;
                    r_brake      <= r_sum[59] ? cmd : '0;
                    r_prev_err   <= r_err;
                    r_prev_speed <= r_speed;
                    if (steady) r_reached <= 1'b1;
                end
                ST_OUT: ;
                default: ;
            endcase

            if (cfg_xfer) begin
                unique case (pstb_pkg::t_cfg_reg'(i_cfg.index))
                    pstb_pkg::REG_TARGET: begin
                        if (i_cfg.data != r_target) begin
                            r_integral <= '0;
                            r_reached  <= 1'b0;
                        end
                        r_target <= i_cfg.data;
                    end
                    pstb_pkg::REG_GAIN_P: r_gain_p <= i_cfg.data[23:0];
                    pstb_pkg::REG_GAIN_I: r_gain_i <= i_cfg.data[23:0];
                    pstb_pkg::REG_GAIN_D: r_gain_d <= i_cfg.data[23:0];
                endcase
            end
        end
    end

endmodule

// ===== design/pstb_checker.sv =====
// Port-level checker for the speed PID block, bound to its top level.
`include "pid_speed_throttle_brake_defines.svh"

module pstb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [pstb_pkg::CMD_W-1:0]  i_throttle,
    input logic [pstb_pkg::CMD_W-1:0]  i_brake,
    input logic                        i_reached
);

    `PSTB_ASSERT_SAME(a_one_cmd_only, i_clk, i_rst_n, i_out_valid, (i_throttle == '0) || (i_brake == '0))
    `PSTB_ASSERT_SAME(a_cmd_in_range, i_clk, i_rst_n, i_out_valid, (i_throttle <= pstb_pkg::CMD_FULL) && (i_brake <= pstb_pkg::CMD_FULL))
    `PSTB_ASSERT_SAME(a_no_take_while_pending, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    `PSTB_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready && !i_out_valid)
    `PSTB_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_throttle) && $stable(i_brake) && $stable(i_reached))

endmodule

bind pid_speed_throttle_brake pstb_checker u_pstb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_throttle  (o_out.throttle),
    .i_brake     (o_out.brake),
    .i_reached   (o_out.speed_reached)
);

// ===== tb/tb_pid_speed_throttle_brake.sv =====
// Testbench for the speed PID block: random handshakes, in-bench command predictor, scoreboard.
`timescale 1ns / 100ps

module tb_pid_speed_throttle_brake;

    localparam longint Q16       = 65536;
    localparam longint SPD_MAX   = 2147483647;
    localparam longint SPD_MIN   = -(longint'(1) << 31);
    localparam longint TERM_SAT  = longint'(1) << 56;
    localparam longint FULL_Q32  = longint'(1) << 32;
    localparam longint INTEG_MAX = (longint'(1) << 47) - 1;
    localparam longint INTEG_MIN = -(longint'(1) << 47);
    localparam int     PHASES    = 10;
    localparam int     PHASE_LEN = 185;

    typedef struct packed {
        logic [pstb_pkg::CMD_W-1:0] throttle;
        logic [pstb_pkg::CMD_W-1:0] brake;
        logic                       reached;
    } t_cmd;

    class t_cmd_scoreboard;
        longint target, kp, ki, kd;
        longint integ, prev_err, prev_spd;
        bit     reached;
        t_cmd   cmd_q[$];
        int     errors, checked, n_integ, n_reached, n_brake;

        function new();
            target = 0;
            kp = pstb_pkg::GAIN_P_RST;
            ki = pstb_pkg::GAIN_I_RST;
            kd = pstb_pkg::GAIN_D_RST;
            integ = 0;
            prev_err = 0;
            prev_spd = 0;
            reached = 0;
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint limit_mul(longint a, longint g);
            if (g == 0 || a == 0) return 0;
            if (mag(a) > TERM_SAT / g) return a < 0 ? -TERM_SAT : TERM_SAT;
            return a * g;
        endfunction

        function void write_reg(pstb_pkg::t_cfg_reg idx, logic [pstb_pkg::SPEED_W-1:0] data);
            longint t;
            case (idx)
                pstb_pkg::REG_TARGET: begin
                    t = longint'($signed(data));
                    if (t != target) begin
                        integ = 0;
                        reached = 0;
                    end
                    target = t;
                end
                pstb_pkg::REG_GAIN_P: kp = longint'(data[pstb_pkg::GAIN_W-1:0]);
                pstb_pkg::REG_GAIN_I: ki = longint'(data[pstb_pkg::GAIN_W-1:0]);
                pstb_pkg::REG_GAIN_D: kd = longint'(data[pstb_pkg::GAIN_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_sample(logic [pstb_pkg::SPEED_W-1:0] spd_bits,
                                  logic [pstb_pkg::DT_W-1:0] dt_bits);
            longint spd, dt, err, acc, diff, rate;
            t_cmd   c;
            spd = longint'($signed(spd_bits));
            dt  = longint'(dt_bits);
            err = target - spd;
            if (err > SPD_MAX) err = SPD_MAX;
            if (err < SPD_MIN) err = SPD_MIN;
            acc = err * kp;
            if (4 * mag(err) < target) begin
                n_integ++;
                acc += limit_mul(integ, ki);
                integ += (err * dt) >>> 16;
                if (integ > INTEG_MAX) integ = INTEG_MAX;
                if (integ < INTEG_MIN) integ = INTEG_MIN;
            end
            if (dt != 0) begin
                diff = err - prev_err;
                rate = diff < 0 ? -((-diff) * Q16 / dt) : diff * Q16 / dt;
                acc += limit_mul(rate, kd);
            end
            prev_err = err;
            if (acc > FULL_Q32) acc = FULL_Q32;
            if (acc < -FULL_Q32) acc = -FULL_Q32;
            if (acc < 0) begin
                c.throttle = '0;
                c.brake    = pstb_pkg::CMD_W'((-acc) >>> 16);
                n_brake++;
            end else begin
                c.throttle = pstb_pkg::CMD_W'(acc >>> 16);
                c.brake    = '0;
            end
            if (dt != 0 && 100 * mag(spd - prev_spd) < dt && 10 * mag(err) < Q16)
                reached = 1;
            prev_spd = spd;
            c.reached = reached;
            if (reached) n_reached++;
            cmd_q = {cmd_q, c};
        endfunction

        function void check_command(t_cmd act);
            t_cmd e;
            if (cmd_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected command throttle %0d brake %0d reached %0d",
                         $time, act.throttle, act.brake, act.reached);
                return;
            end
            e = cmd_q.pop_front();
            if (act.throttle !== e.throttle) begin
                errors++;
                $display("%0t: command %0d throttle expected %0d got %0d",
                         $time, checked, e.throttle, act.throttle);
            end
            if (act.brake !== e.brake) begin
                errors++;
                $display("%0t: command %0d brake expected %0d got %0d",
                         $time, checked, e.brake, act.brake);
            end
            if (act.reached !== e.reached) begin
                errors++;
                $display("%0t: command %0d reached expected %0d got %0d",
                         $time, checked, e.reached, act.reached);
            end
            checked++;
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pstb_cfg_if cfg_if ();
    pstb_in_if  smp_if ();
    pstb_out_if cmd_if ();

    pid_speed_throttle_brake u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (smp_if),
        .o_out   (cmd_if)
    );

    t_cmd_scoreboard sb;
    bit     calm;
    int     stall_left = 0;
    int     hold_left = 0;
    int     holds_done = 0;
    int     n_settings;
    longint last_spd;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic longint clip_speed(longint v);
        if (v > SPD_MAX) return SPD_MAX;
        if (v < SPD_MIN) return SPD_MIN;
        return v;
    endfunction

    function automatic logic [pstb_pkg::SPEED_W-1:0] pick_speed(longint tgt);
        int     r, sh;
        int     shifts[6] = '{4, 10, 13, 16, 20, 26};
        longint off;
        r = $urandom_range(99);
        if (r < 45) begin
            sh  = shifts[$urandom_range(5)];
            off = longint'($urandom_range(0, 1 << sh));
            if ($urandom_range(1)) off = -off;
            return pstb_pkg::SPEED_W'(clip_speed(tgt + off));
        end
        if (r < 70) return pstb_pkg::SPEED_W'(clip_speed(last_spd + $urandom_range(0, 6) - 3));
        if (r < 88) return $urandom();
        case ($urandom_range(4))
            0: return pstb_pkg::SPEED_W'(SPD_MAX);
            1: return pstb_pkg::SPEED_W'(SPD_MIN);
            2: return '0;
            3: return '1;
            default: return pstb_pkg::SPEED_W'(1);
        endcase
    endfunction

    function automatic logic [pstb_pkg::DT_W-1:0] pick_dt();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 18) return '1;
        if (r < 24) return pstb_pkg::DT_W'(1);
        if (r < 60) return pstb_pkg::DT_W'($urandom_range(1, 65535));
        return pstb_pkg::DT_W'($urandom_range(256, 8192));
    endfunction

    function automatic logic [pstb_pkg::GAIN_W-1:0] pick_gain(
        logic [pstb_pkg::GAIN_W-1:0] rst_val);
        int r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 25) return '1;
        if (r < 45) return rst_val;
        if (r < 70) return pstb_pkg::GAIN_W'($urandom_range(0, 4096));
        return pstb_pkg::GAIN_W'($urandom());
    endfunction

    function automatic logic [pstb_pkg::SPEED_W-1:0] pick_target();
        int r;
        r = $urandom_range(99);
        if (r < 45) return pstb_pkg::SPEED_W'($urandom_range(1 << 16, 100 << 16));
        if (r < 65) return $urandom();
        if (r < 80) return pstb_pkg::SPEED_W'(-longint'($urandom_range(1, 50 << 16)));
        if (r < 87) return pstb_pkg::SPEED_W'(SPD_MAX);
        if (r < 94) return pstb_pkg::SPEED_W'(SPD_MIN);
        return pstb_pkg::SPEED_W'($urandom_range(0, 1));
    endfunction

    task automatic send_sample(logic [pstb_pkg::SPEED_W-1:0] spd,
                               logic [pstb_pkg::DT_W-1:0] dt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.measured_speed <= spd;
        smp_if.time_step      <= dt;
        do @(posedge i_clk); while (!smp_if.ready);
        sb.note_sample(spd, dt);
        last_spd = longint'($signed(spd));
    endtask

    task automatic settle();
        smp_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(pstb_pkg::t_cfg_reg idx, logic [pstb_pkg::SPEED_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_setting(logic [pstb_pkg::SPEED_W-1:0] tgt,
                                logic [pstb_pkg::GAIN_W-1:0] gp,
                                logic [pstb_pkg::GAIN_W-1:0] gi,
                                logic [pstb_pkg::GAIN_W-1:0] gd);
        settle();
        cfg_write(pstb_pkg::REG_TARGET, tgt);
        cfg_write(pstb_pkg::REG_GAIN_P, pstb_pkg::SPEED_W'(gp));
        cfg_write(pstb_pkg::REG_GAIN_I, pstb_pkg::SPEED_W'(gi));
        cfg_write(pstb_pkg::REG_GAIN_D, pstb_pkg::SPEED_W'(gd));
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic rewrite_target(logic [pstb_pkg::SPEED_W-1:0] tgt);
        settle();
        cfg_write(pstb_pkg::REG_TARGET, tgt);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stalls plus two long hold-offs to back up the input
    always @(posedge i_clk) begin
        t_cmd got;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            got.throttle = cmd_if.throttle;
            got.brake    = cmd_if.brake;
            got.reached  = cmd_if.speed_reached;
            sb.check_command(got);
        end
        if (i_rst_n && hold_left == 0 && holds_done < 2
            && sb.checked >= 400 + 700 * holds_done) begin
            hold_left = 500;
            holds_done++;
        end
        if (!i_rst_n) begin
            cmd_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            cmd_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            cmd_if.ready <= 1'b0;
        end else begin
            cmd_if.ready <= 1'b1;
            if ($urandom_range(99) < 30) stall_left = pick_gap();
        end
    end

    initial begin
        #15ms;
        $display("pid_speed_throttle_brake test failed");
        $finish;
    end

    initial begin
        logic [pstb_pkg::SPEED_W-1:0] tgt;
        sb = new();
        calm = 0;
        n_settings = 0;
        last_spd = 0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = pstb_pkg::REG_TARGET;
        cfg_if.data = '0;
        smp_if.valid = 1'b0;
        smp_if.measured_speed = '0;
        smp_if.time_step = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero target, so no integration; steady zero speed latches reached
        send_sample('0, '0);
        send_sample(pstb_pkg::SPEED_W'(SPD_MAX), '1);
        send_sample(pstb_pkg::SPEED_W'(SPD_MIN), '1);
        send_sample(pstb_pkg::SPEED_W'(SPD_MIN), '0);
        send_sample('1, pstb_pkg::DT_W'(1));
        send_sample(pstb_pkg::SPEED_W'(1), pstb_pkg::DT_W'(1));
        send_sample('0, '1);
        send_sample('0, '1);

        // positive target: integration window, zero time step, steady at target
        load_setting(pstb_pkg::SPEED_W'(10 * Q16), pstb_pkg::GAIN_P_RST,
                     pstb_pkg::GAIN_I_RST, pstb_pkg::GAIN_D_RST);
        send_sample(pstb_pkg::SPEED_W'(10 * Q16 - 'h8000), pstb_pkg::DT_W'(1000));
        send_sample(pstb_pkg::SPEED_W'(10 * Q16 - 'h8000), pstb_pkg::DT_W'(1000));
        send_sample(pstb_pkg::SPEED_W'(10 * Q16 + 'h4000), '0);
        send_sample(pstb_pkg::SPEED_W'(10 * Q16), '1);
        send_sample(pstb_pkg::SPEED_W'(10 * Q16), '1);
        rewrite_target(pstb_pkg::SPEED_W'(10 * Q16));
        send_sample(pstb_pkg::SPEED_W'(10 * Q16 + 'h4000), '1);
        send_sample('0, pstb_pkg::DT_W'(500));
        send_sample(pstb_pkg::SPEED_W'(13 * Q16), pstb_pkg::DT_W'(2));
        send_sample(pstb_pkg::SPEED_W'(SPD_MAX), pstb_pkg::DT_W'(1));
        rewrite_target(pstb_pkg::SPEED_W'(11 * Q16));
        send_sample(pstb_pkg::SPEED_W'(11 * Q16), '1);

        // negative target: never integrates
        load_setting(pstb_pkg::SPEED_W'(-5 * Q16), '1, '1, '1);
        send_sample(pstb_pkg::SPEED_W'(-5 * Q16), pstb_pkg::DT_W'(1000));
        send_sample(pstb_pkg::SPEED_W'(SPD_MIN), pstb_pkg::DT_W'(1));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_setting(pstb_pkg::SPEED_W'(SPD_MAX), '1, '1, '1);
                1: load_setting(pstb_pkg::SPEED_W'(SPD_MIN), '0, '0, '0);
                2: load_setting('0, pick_gain(pstb_pkg::GAIN_P_RST),
                                pick_gain(pstb_pkg::GAIN_I_RST),
                                pick_gain(pstb_pkg::GAIN_D_RST));
                default: load_setting(pick_target(), pick_gain(pstb_pkg::GAIN_P_RST),
                                      pick_gain(pstb_pkg::GAIN_I_RST),
                                      pick_gain(pstb_pkg::GAIN_D_RST));
            endcase
            calm = (p % 4 == 3);
            tgt = pstb_pkg::SPEED_W'(sb.target);
            last_spd = sb.target;
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (k == PHASE_LEN / 2 && $urandom_range(1)) begin
                    if ($urandom_range(1)) rewrite_target(tgt);
                    else rewrite_target(tgt + pstb_pkg::SPEED_W'($urandom_range(1, 1 << 15)));
                    tgt = pstb_pkg::SPEED_W'(sb.target);
                end
                send_sample(pick_speed(sb.target), pick_dt());
            end
            calm = 0;
        end

        smp_if.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("checked %0d commands over %0d settings, %0d of them braking",
                 sb.checked, n_settings, sb.n_brake);
        $display("integration ran on %0d ticks, reached was set on %0d, %0d long hold-offs",
                 sb.n_integ, sb.n_reached, holds_done);
        if (sb.errors == 0) begin
            $display("pid_speed_throttle_brake test passed");
        end else begin
            $display("pid_speed_throttle_brake test failed");
        end
        $finish;
    end

endmodule

// ===== pid_speed_throttle_brake.f =====
+incdir+design
design/pstb_pkg.sv
design/pstb_channels.sv
design/pid_speed_throttle_brake.sv
design/pstb_checker.sv
tb/tb_pid_speed_throttle_brake.sv
